>>> sv/srwp_pkg.sv
`default_nettype none

package srwp_pkg;

  // Quarter-wave table: entries 0..SINE_ENTRIES, unsigned Q15
  localparam int SINE_ENTRIES = 4096;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN   = 3'd0,
    REG_RANGE_MAX   = 3'd1,
    REG_ANGLE_START = 3'd2,
    REG_ANGLE_STEP  = 3'd3,
    REG_FRAME_X     = 3'd4,
    REG_FRAME_Y     = 3'd5,
    REG_FRAME_YAW   = 3'd6,
    REG_FRAME_VALID = 3'd7
  } cfg_reg_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Taylor divisors (2k)(2k+1) for k = 1..5
  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  typedef logic [15:0] sine_rom_t [SINE_ENTRIES+1];

  // Built at elaboration: degree-11 Taylor sum in Q30, rounded half up to Q15
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_ENTRIES);
      t = x;
      s = $signed(x);
      for (int k = 1; k <= 5; k++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / TAYLOR_DIV[k-1];
        if (k % 2 == 1) begin
          s = s - $signed(t);
        end else begin
          s = s + $signed(t);
        end
      end
      if (s < 0) begin
        s = 64'sd0;
      end
      rom[i] = 16'(($unsigned(s) + 64'd16384) >> 15);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

>>> sv/scan_range_to_world_points.sv
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_ready    range_mm, range_finite, last_sample
// out       out_valid / out_ready  point_kept, world_x_mm, world_y_mm, sweep_end
// cfg       cfg_wr_en              cfg_index, cfg_data
//
// One item per cycle unless out_ready stalls; out_valid is registered from v3.
// Stages: input register (angle), sine ROM read, range*trig multiply, round/add.
// The ROM has two read ports (sine and cosine) with registered data.
// rst is synchronous; it clears the stage valids, sweep state and config registers.
// A stall on out_ready holds every stage that has no free slot behind it.

module scan_range_to_world_points
  import srwp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,

  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,

  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [15:0]             range_mm,
  input  wire logic                    range_finite,
  input  wire logic                    last_sample,

  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         point_kept,
  output logic signed [24:0]           world_x_mm,
  output logic signed [24:0]           world_y_mm,
  output logic                         sweep_end
);

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  // configuration
  logic [15:0]        range_lo;
  logic [15:0]        range_hi;
  logic [15:0]        angle_start;
  logic signed [15:0] angle_step;
  logic signed [23:0] frame_x;
  logic signed [23:0] frame_y;
  logic [15:0]        frame_yaw;
  logic               frame_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_lo    <= 16'd0;
      range_hi    <= 16'hFFFF;
      angle_start <= 16'd0;
      angle_step  <= 16'sd0;
      frame_x     <= 24'sd0;
      frame_y     <= 24'sd0;
      frame_yaw   <= 16'd0;
      frame_valid <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANGE_MIN:   range_lo    <= cfg_data[15:0];
        REG_RANGE_MAX:   range_hi    <= cfg_data[15:0];
        REG_ANGLE_START: angle_start <= cfg_data[15:0];
        REG_ANGLE_STEP:  angle_step  <= $signed(cfg_data[15:0]);
        REG_FRAME_X:     frame_x     <= $signed(cfg_data[23:0]);
        REG_FRAME_Y:     frame_y     <= $signed(cfg_data[23:0]);
        REG_FRAME_YAW:   frame_yaw   <= cfg_data[15:0];
        REG_FRAME_VALID: frame_valid <= cfg_data[0];
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or its content moves on
  logic v1, v2, v3;
  logic en1, en2, en3, en_o;

  assign en_o     = !out_valid || out_ready;
  assign en3      = !v3 || en_o;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // sweep angle state
  logic [15:0] sample_angle;
  logic        at_sweep_start;
  logic [15:0] ang;
  logic        kept_in;

  assign ang     = at_sweep_start ? angle_start : sample_angle;
  assign kept_in = range_finite && (range_mm >= range_lo) && (range_mm <= range_hi)
                   && frame_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_angle   <= 16'd0;
      at_sweep_start <= 1'b1;
    end else if (in_acc) begin
      sample_angle   <= ang + $unsigned(angle_step);
      at_sweep_start <= last_sample;
    end
  end

  // stage 1: input register
  logic [15:0] s1_range;
  logic        s1_kept;
  logic        s1_last;
  logic [15:0] s1_theta;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (in_acc) begin
      s1_range <= range_mm;
      s1_kept  <= kept_in;
      s1_last  <= last_sample;
      s1_theta <= ang + frame_yaw;
    end
  end

  // quadrant folding; cosine is the next quadrant with the same offset
  logic [1:0]            quad_s, quad_c;
  logic [31:0]           idx_scaled;
  logic [SINE_IDX_W-1:0] idx;
  logic [SINE_IDX_W-1:0] idx_mirror;
  logic [SINE_IDX_W-1:0] addr_s, addr_c;

  assign quad_s     = s1_theta[15:14];
  assign quad_c     = quad_s + 2'd1;
  assign idx_scaled = (32'(s1_theta[13:0]) * 32'(SINE_ENTRIES)) >> 14;
  assign idx        = idx_scaled[SINE_IDX_W-1:0];
  assign idx_mirror = SINE_IDX_W'(SINE_ENTRIES) - idx;
  assign addr_s     = quad_s[0] ? idx_mirror : idx;
  assign addr_c     = quad_c[0] ? idx_mirror : idx;

  // stage 2: ROM read
  logic [15:0] s2_sin, s2_cos;
  logic        s2_neg_s, s2_neg_c;
  logic [15:0] s2_range;
  logic        s2_kept;
  logic        s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      s2_sin   <= SINE_ROM[addr_s];
      s2_cos   <= SINE_ROM[addr_c];
      s2_neg_s <= quad_s[1];
      s2_neg_c <= quad_c[1];
      s2_range <= s1_range;
      s2_kept  <= s1_kept;
      s2_last  <= s1_last;
    end
  end

  // stage 3: products
  logic [31:0]        mag_x, mag_y;
  logic signed [32:0] s3_px, s3_py;
  logic               s3_kept;
  logic               s3_last;

  assign mag_x = 32'(s2_range) * 32'(s2_cos);
  assign mag_y = 32'(s2_range) * 32'(s2_sin);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      s3_px   <= s2_neg_c ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      s3_py   <= s2_neg_s ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
      s3_kept <= s2_kept;
      s3_last <= s2_last;
    end
  end

  // round half up to mm, then offset by the frame position
  logic signed [32:0] sum_x, sum_y;
  logic signed [17:0] off_x, off_y;
  logic signed [24:0] wx, wy;

  assign sum_x = s3_px + 33'sd16384;
  assign sum_y = s3_py + 33'sd16384;
  assign off_x = sum_x[32:15];
  assign off_y = sum_y[32:15];
  assign wx    = {frame_x[23], frame_x} + {{7{off_x[17]}}, off_x};
  assign wy    = {frame_y[23], frame_y} + {{7{off_y[17]}}, off_y};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= v3;
    end
    if (en_o) begin
      point_kept <= s3_kept;
      world_x_mm <= s3_kept ? wx : 25'sd0;
      world_y_mm <= s3_kept ? wy : 25'sd0;
      sweep_end  <= s3_last;
    end
  end

endmodule

`default_nettype wire

>>> tb/scan_range_to_world_points_tb.sv
import srwp_pkg::*;

typedef struct {
  bit                 kept;
  logic signed [24:0] x_mm;
  logic signed [24:0] y_mm;
  bit                 sweep_end;
} world_point_t;

// Predicts world points from accepted range samples and checks the block's output.
class point_scoreboard;
  logic [15:0]        range_lo;
  logic [15:0]        range_hi;
  logic [15:0]        start_angle;
  logic [15:0]        step;
  logic signed [23:0] pose_x;
  logic signed [23:0] pose_y;
  logic [15:0]        yaw;
  bit                 pose_known;

  logic [15:0]        angle;
  bit                 reload_angle;

  int unsigned        quarter_wave [SINE_ENTRIES+1];
  world_point_t       expected_points[$];
  int unsigned        mismatches;
  int unsigned        checked;

  function new();
    longint unsigned x;
    longint unsigned t;
    longint          s;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      // pi/2 in Q30
      x = (64'd1686629713 * longint'(i)) / SINE_ENTRIES;
      t = x;
      s = longint'(x);
      for (int k = 1; k <= 5; k++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          s -= longint'(t);
        end else begin
          s += longint'(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      quarter_wave[i] = int'((s + 16384) >>> 15);
    end
    range_lo     = 16'd0;
    range_hi     = 16'hFFFF;
    start_angle  = 16'd0;
    step         = 16'd0;
    pose_x       = '0;
    pose_y       = '0;
    yaw          = 16'd0;
    pose_known   = 1'b0;
    angle        = 16'd0;
    reload_angle = 1'b1;
    mismatches   = 0;
    checked      = 0;
  endfunction

  function void set_reg(cfg_reg_t idx, logic [23:0] d);
    case (idx)
      REG_RANGE_MIN:   range_lo    = d[15:0];
      REG_RANGE_MAX:   range_hi    = d[15:0];
      REG_ANGLE_START: start_angle = d[15:0];
      REG_ANGLE_STEP:  step        = d[15:0];
      REG_FRAME_X:     pose_x      = d;
      REG_FRAME_Y:     pose_y      = d;
      REG_FRAME_YAW:   yaw         = d[15:0];
      REG_FRAME_VALID: pose_known  = d[0];
      default: ;
    endcase
  endfunction

  // Signed Q15 sine of a binary angle, mirrored from the quarter wave
  function longint sin_q15(logic [15:0] a);
    int unsigned idx;
    longint      v;
    idx = (int'(a[13:0]) * SINE_ENTRIES) / 16384;
    v = a[14] ? quarter_wave[SINE_ENTRIES - idx] : quarter_wave[idx];
    return a[15] ? -v : v;
  endfunction

  function void note_sample(logic [15:0] range, bit finite, bit last);
    world_point_t p;
    logic [15:0]  theta;
    longint       s_q;
    longint       c_q;
    if (reload_angle) begin
      angle = start_angle;
    end
    p.kept = finite && range >= range_lo && range <= range_hi && pose_known;
    p.x_mm = '0;
    p.y_mm = '0;
    p.sweep_end = last;
    if (p.kept) begin
      theta = angle + yaw;
      s_q = sin_q15(theta);
      c_q = sin_q15(theta + 16'd16384);
      // round half up: floor((r*trig + 0.5) in Q15)
      p.x_mm = 25'(longint'(pose_x) + ((longint'(range) * c_q + 16384) >>> 15));
      p.y_mm = 25'(longint'(pose_y) + ((longint'(range) * s_q + 16384) >>> 15));
    end
    angle = angle + step;
    reload_angle = last;
    expected_points = {expected_points, p};
  endfunction

  function void check_point(logic kept, logic signed [24:0] x, logic signed [24:0] y,
                            logic eop);
    world_point_t want;
    checked++;
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("point %0d: no item pending, got kept %0b x %0d y %0d end %0b",
                 checked, kept, x, y, eop);
      end
      return;
    end
    want = expected_points.pop_front();
    if (kept !== want.kept || x !== want.x_mm || y !== want.y_mm ||
        eop !== want.sweep_end) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("point %0d (exp/got): kept %0b/%0b x %0d/%0d y %0d/%0d end %0b/%0b",
                 checked, want.kept, kept, want.x_mm, x, want.y_mm, y,
                 want.sweep_end, eop);
      end
    end
  endfunction

  function int pending();
    return expected_points.size();
  endfunction
endclass

module scan_range_to_world_points_tb;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [15:0]           range_mm = '0;
  logic                  range_finite = 1'b0;
  logic                  last_sample = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  point_kept;
  logic signed [24:0]    world_x_mm;
  logic signed [24:0]    world_y_mm;
  logic                  sweep_end;

  bit                    calm = 1'b0;
  int unsigned           idle_cycles = 0;
  int unsigned           sweep_left = 0;
  point_scoreboard       sb;

  scan_range_to_world_points dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick16();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 16'h0000;
    if (r < 24) return 16'hFFFF;
    if (r < 30) return 16'h8000;
    if (r < 36) return 16'h7FFF;
    return 16'($urandom);
  endfunction

  function automatic logic [23:0] pick24();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 24'h800000;
    if (r < 24) return 24'h7FFFFF;
    if (r < 32) return 24'h000000;
    return 24'($urandom);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [23:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  // Unused upper data bits carry junk; the block must mask them.
  task automatic load_setting(logic [15:0] lo, logic [15:0] hi, logic [15:0] start,
                              logic [15:0] stp, logic [23:0] fx, logic [23:0] fy,
                              logic [15:0] hdg, bit valid);
    write_reg(REG_RANGE_MIN,   {8'($urandom), lo});
    write_reg(REG_RANGE_MAX,   {8'($urandom), hi});
    write_reg(REG_ANGLE_START, {8'($urandom), start});
    write_reg(REG_ANGLE_STEP,  {8'($urandom), stp});
    write_reg(REG_FRAME_X,     fx);
    write_reg(REG_FRAME_Y,     fy);
    write_reg(REG_FRAME_YAW,   {8'($urandom), hdg});
    write_reg(REG_FRAME_VALID, {23'($urandom), valid});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_sample(logic [15:0] r, bit fin, bit last);
    int unsigned n;
    in_valid     <= 1'b1;
    range_mm     <= r;
    range_finite <= fin;
    last_sample  <= last;
    do @(posedge clk); while (!in_ready);
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned count);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] r;
    logic [15:0] stp;
    int unsigned mode;
    int unsigned pick;
    bit          fin;
    calm = ($urandom_range(0, 3) == 0);
    a = 16'($urandom);
    b = 16'($urandom);
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      lo = 16'h0000;
      hi = 16'hFFFF;
    end else if (mode < 8) begin
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
    end else if (mode == 8) begin
      lo = (a < b) ? b : a;
      hi = (a < b) ? a : b;
    end else begin
      lo = a;
      hi = a;
    end
    stp = ($urandom_range(0, 2) == 0) ? pick16() : 16'($urandom_range(0, 2048) - 1024);
    load_setting(lo, hi, pick16(), stp, pick24(), pick24(), pick16(),
                 $urandom_range(0, 99) < 85);
    repeat (count) begin
      if (sweep_left == 0) begin
        sweep_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) r = 16'($urandom_range(lo, hi));
      else if (pick < 75) r = lo;
      else if (pick < 80) r = hi;
      else if (pick < 83) r = lo - 16'd1;
      else if (pick < 86) r = hi + 16'd1;
      else r = 16'($urandom);
      fin = $urandom_range(0, 99) < 92;
      send_sample(r, fin, sweep_left == 1);
      sweep_left--;
      if ($urandom_range(0, 199) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  // Receiver: random stalls on out_ready
  initial begin
    int unsigned n;
    do @(posedge clk); while (rst);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      n = gap_len();
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Output is checked before the input of the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_point(point_kept, world_x_mm, world_y_mm, sweep_end);
      end
      if (in_valid && in_ready) begin
        sb.note_sample(range_mm, range_finite, last_sample);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // quarter-turn steps, frame at the position extremes, then a sweep reload
    load_setting(16'd0, 16'hFFFF, 16'd0, 16'd16384, 24'h7FFFFF, 24'h800000, 16'd0, 1'b1);
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b0);
    send_sample(16'd32767, 1'b1, 1'b1);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'd1, 1'b1, 1'b0);
    send_sample(16'd54321, 1'b1, 1'b0);
    send_sample(16'd40000, 1'b1, 1'b1);
    wait_drained();

    // range window edges, angle wrap through yaw and the most negative step
    load_setting(16'd100, 16'd200, 16'hFFFF, 16'h8000, 24'h800000, 24'h7FFFFF,
                 16'hFFFF, 1'b1);
    send_sample(16'd99, 1'b1, 1'b0);
    send_sample(16'd100, 1'b1, 1'b0);
    send_sample(16'd200, 1'b1, 1'b0);
    send_sample(16'd201, 1'b1, 1'b0);
    send_sample(16'd150, 1'b0, 1'b0);
    send_sample(16'd150, 1'b1, 1'b1);
    send_sample(16'd150, 1'b1, 1'b0);
    wait_drained();

    // crossed limits keep nothing
    load_setting(16'd300, 16'd200, 16'h4000, 16'h7FFF, 24'd5000, 24'd7000, 16'h2000, 1'b1);
    send_sample(16'd250, 1'b1, 1'b0);
    send_sample(16'd300, 1'b1, 1'b0);
    send_sample(16'd200, 1'b1, 1'b1);
    wait_drained();

    // unknown pose keeps no item
    load_setting(16'd0, 16'hFFFF, 16'h1234, 16'd5, 24'd1, 24'd2, 16'd3, 1'b0);
    send_sample(16'd500, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b1);
    wait_drained();

    for (int p = 0; p < 13; p++) begin
      random_phase(150);
    end
    calm = 1'b0;
    wait_drained();

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
